>>> rtl/sptrm_pkg.sv
// sparse table range minimum: shared types, sizes and helper functions
// no dependencies; imported by every module of the block except sptrm_ram
package sptrm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int PW     = CNT_W + 1;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RAM_DEPTH = LEVELS * (2 ** IDX_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam int DATA_W = 32;
    localparam int POS_W  = 10;
    localparam int QLEN_W = POS_W + 1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_RANGE = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         left;
        logic [POS_W-1:0]         right;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic [1:0]               status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FILL,
        S_QLOOK,
        S_QFIRST,
        S_QLAST,
        S_REPLY
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_VALUE,
        ACC_RDATA,
        ACC_MIN
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
        logic    wr_value;
    } dp_ctl_t;

    // signed minimum, first operand wins a tie
    function automatic logic signed [DATA_W-1:0] smin(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a <= b) ? a : b;
    endfunction

    // floor(log2(len)) clamped to the top level of the table
    function automatic logic [LVL_W-1:0] floor_log2(input logic [QLEN_W-1:0] len);
        int r;
        r = 0;
        for (int i = 0; i < QLEN_W; i++) begin
            if (len[i]) begin
                r = i;
            end
        end
        if (r > LEVELS - 1) begin
            r = LEVELS - 1;
        end
        return LVL_W'(r);
    endfunction

endpackage

>>> rtl/sptrm_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module sptrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sptrm_dp.sv
// shared compare unit and running minimum register
// depends on sptrm_pkg
module sptrm_dp
    import sptrm_pkg::*;
(
    input  logic                     clk,
    input  dp_ctl_t                  ctl,
    input  logic signed [DATA_W-1:0] load_value,
    input  logic signed [DATA_W-1:0] rdata,
    output logic signed [DATA_W-1:0] wdata,
    output logic signed [DATA_W-1:0] min_out
);

    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc_next;
    logic signed [DATA_W-1:0] min_c;

    // during table fill, rdata is the older window and acc the one just built
    assign min_c   = smin(rdata, acc_reg);
    assign min_out = min_c;
    assign wdata   = ctl.wr_value ? load_value : min_c;

    always_comb
    begin
        unique case (ctl.op)
            ACC_VALUE: acc_next = load_value;
            ACC_RDATA: acc_next = rdata;
            ACC_MIN:   acc_next = min_c;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

>>> rtl/sptrm_seq.sv
// sequencer: request capture, table fill and query steps, result register
// depends on sptrm_pkg
module sptrm_seq
    import sptrm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_t                     req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_t                     rsp,
    output dp_ctl_t                  dp_ctl,
    output logic signed [DATA_W-1:0] load_value,
    input  logic signed [DATA_W-1:0] dp_min,
    output logic                     ram_we,
    output logic [RAM_AW-1:0]        ram_waddr,
    output logic                     ram_re,
    output logic [RAM_AW-1:0]        ram_raddr
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [PW-1:0]     pow_reg, pow_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    req_t              req_reg, req_next;
    rsp_t              res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              full;
    logic              slot_free;
    logic [PW-1:0]     cnt_plus;
    logic [PW-1:0]     fill_start;
    logic [PW-1:0]     next_start;
    logic              more;
    logic              bad_range;
    logic [QLEN_W-1:0] qlen;
    logic [LVL_W-1:0]  qlg;
    logic [QLEN_W-1:0] qpow;
    logic [QLEN_W-1:0] qsecond;

    assign full       = (32'(count_reg) == MAX_ELEMENTS);
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign cnt_plus   = PW'(count_reg) + PW'(1);
    assign fill_start = cnt_plus - pow_reg;
    assign next_start = cnt_plus - (pow_reg << 1);
    // another level fits when it stays inside the table and the loaded prefix
    assign more       = ((32'(lvl_reg) + 1) < LEVELS) && ((pow_reg << 1) <= cnt_plus);

    assign bad_range  = (req_reg.left > req_reg.right)
                     || (32'(req_reg.right) >= 32'(count_reg));
    assign qlen       = QLEN_W'(req_reg.right) - QLEN_W'(req_reg.left) + QLEN_W'(1);
    assign qlg        = floor_log2(qlen);
    assign qpow       = QLEN_W'(1) << qlg;
    assign qsecond    = QLEN_W'(req_reg.right) + QLEN_W'(1) - qpow;

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign load_value = req_reg.value;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == ACT_LOAD && !full)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (req.action == ACT_QUERY)
                    begin
                        state_next = S_QLOOK;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_LOAD, S_FILL:
            begin
                state_next = more ? S_FILL : S_REPLY;
            end
            S_QLOOK:
            begin
                state_next = bad_range ? S_REPLY : S_QFIRST;
            end
            S_QFIRST:
            begin
                state_next = S_QLAST;
            end
            S_QLAST:
            begin
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_ctl         = '{op: ACC_HOLD, wr_value: 1'b0};
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        count_next     = count_reg;
        lvl_next       = lvl_reg;
        pow_next       = pow_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '{min_value: '0, status: STAT_OK};
                    lvl_next = '0;
                    pow_next = PW'(1);
                    if (req.action == ACT_LOAD && full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    if (req.action == ACT_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            S_LOAD:
            begin
                // level 0 entry is the value itself
                ram_we    = 1'b1;
                ram_waddr = RAM_AW'({lvl_reg, count_reg[IDX_W-1:0]});
                dp_ctl    = '{op: ACC_VALUE, wr_value: 1'b1};
                if (more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = RAM_AW'({lvl_reg, next_start[IDX_W-1:0]});
                    lvl_next  = lvl_reg + LVL_W'(1);
                    pow_next  = pow_reg << 1;
                end
                else
                begin
                    count_next = cnt_plus[CNT_W-1:0];
                end
            end
            S_FILL:
            begin
                // window ending at the new index = min(older half, newer half)
                ram_we    = 1'b1;
                ram_waddr = RAM_AW'({lvl_reg, fill_start[IDX_W-1:0]});
                dp_ctl    = '{op: ACC_MIN, wr_value: 1'b0};
                if (more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = RAM_AW'({lvl_reg, next_start[IDX_W-1:0]});
                    lvl_next  = lvl_reg + LVL_W'(1);
                    pow_next  = pow_reg << 1;
                end
                else
                begin
                    count_next = cnt_plus[CNT_W-1:0];
                end
            end
            S_QLOOK:
            begin
                if (bad_range)
                begin
                    res_next.status = STAT_BAD_RANGE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = RAM_AW'({qlg, IDX_W'(req_reg.left)});
                    lvl_next  = qlg;
                    idx_next  = IDX_W'(qsecond);
                end
            end
            S_QFIRST:
            begin
                ram_re    = 1'b1;
                ram_raddr = RAM_AW'({lvl_reg, idx_reg});
                dp_ctl    = '{op: ACC_RDATA, wr_value: 1'b0};
            end
            S_QLAST:
            begin
                res_next.min_value = dp_min;
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lvl_reg       <= '0;
            pow_reg       <= PW'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lvl_reg       <= lvl_next;
            pow_reg       <= pow_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

>>> rtl/sparse_table_range_minimum.sv
// top level of the sparse table range minimum engine
// depends on sptrm_pkg, sptrm_seq, sptrm_dp and sptrm_ram
//
// usage
//   request channel (req_valid, req_stall, req): action load appends a value
//   at the next index, query asks for the minimum over left..right, clear
//   empties the table; every request gives exactly one response
//   response channel (rsp_valid, rsp_stall, rsp): min_value and status
// steps, from the accepted request to the response
//   load  : the value is written at level 0, then one table window is
//           written per cycle for each higher level that fits, through the
//           single write port of the table ram
//   query : two reads of the table ram through its one read port, then
//           the minimum of the two windows goes into the result
// one request at a time: req_stall is high from acceptance until the
// response has been placed in the output register
// a stalled response holds in the output register; the block waits with
// the next response until it has been taken
// reset clears the element count and both handshakes; the table ram is not
// cleared, entries are only read after they have been rewritten
module sparse_table_range_minimum
    import sptrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // control from the sequencer to the shared compare unit
    dp_ctl_t                  dp_ctl;
    logic signed [DATA_W-1:0] load_value;
    logic signed [DATA_W-1:0] dp_min;
    logic signed [DATA_W-1:0] wdata;

    // table ram: level in the upper address bits, start index below
    logic                     ram_we;
    logic [RAM_AW-1:0]        ram_waddr;
    logic                     ram_re;
    logic [RAM_AW-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    sptrm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .dp_ctl     (dp_ctl),
        .load_value (load_value),
        .dp_min     (dp_min),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    // one signed compare shared by table fill and query
    sptrm_dp u_dp (
        .clk        (clk),
        .ctl        (dp_ctl),
        .load_value (load_value),
        .rdata      (signed'(ram_rdata)),
        .wdata      (wdata),
        .min_out    (dp_min)
    );

    sptrm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (DATA_W'(wdata)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/sptrm_check.sv
// port level checks for the sparse table range minimum engine
// depends on sptrm_pkg; bound to sparse_table_range_minimum
module sptrm_check
    import sptrm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // stalled response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // stalled request stays put
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // one request at a time: busy right after an accepted request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous one in flight");

    // error responses carry a zero minimum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_OK |-> rsp.min_value == '0)
        else $error("error response with non-zero minimum");

    // no new response in the cycle right after acceptance
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
        else $error("response appeared too early");

endmodule

bind sparse_table_range_minimum sptrm_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
